FILE: rtl/bitmap_block_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// bitmap block allocator assertion macros
// shared concurrent checks, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

FILE: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// sizes, codes and shared structs of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TOTAL_BLOCKS = 1024;
  localparam int WORD_BITS    = 32;
  localparam int MAP_WORDS    = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;

  localparam int IDX_W      = $clog2(TOTAL_BLOCKS);
  localparam int CNT_W      = $clog2(TOTAL_BLOCKS + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);

  localparam logic [CNT_W-1:0]      TOTAL_CNT = CNT_W'(TOTAL_BLOCKS);
  localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(MAP_WORDS - 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_ALLOC_ONE   = 2'd0,
    MODE_FREE_ONE    = 2'd1,
    MODE_ALLOC_RANGE = 2'd2,
    MODE_FREE_RANGE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_PAST_END = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    word_t                 wr_data;
  } mem_cmd_t;

  typedef struct packed {
    logic                  alloc_one;
    logic                  fill;
    logic [WORD_IDX_W-1:0] word;
    logic [CNT_W-1:0]      start;
    logic [CNT_W-1:0]      stop;
  } word_req_t;

  typedef struct packed {
    word_t            new_data;
    logic             found;
    logic [BIT_W-1:0] bit_pos;
  } word_res_t;

endpackage

FILE: rtl/bba_if.sv
// ----------------------------------------------------------------------------
// bba channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bba_in_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [IDX_W-1:0] position;
  logic [CNT_W-1:0] count;

  modport source (output valid, output mode, output position, output count, input ready);
  modport sink (input valid, input mode, input position, input count, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] block_index;
  logic [1:0]       status;
  logic [CNT_W-1:0] free_blocks;

  modport source (output valid, output block_index, output status, output free_blocks,
                  input ready);
  modport sink (input valid, input block_index, input status, input free_blocks,
                output ready);
endinterface

FILE: rtl/bba_map_mem.sv
// ----------------------------------------------------------------------------
// bba_map_mem
// free bitmap word store, one read and one write port, registered read;
// per-word valid bits make unwritten words read as all free
// ----------------------------------------------------------------------------
module bba_map_mem import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_cmd_t cmd,
  output word_t    rd_data
);

  word_t                mem_r [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_r;
  word_t                rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[cmd.wr_addr] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= valid_r[cmd.rd_addr] ? mem_r[cmd.rd_addr] : '1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bba_word_unit.sv
// ----------------------------------------------------------------------------
// bba_word_unit
// shared word update: lowest free bit search, or set/clear of a run of bits
// ----------------------------------------------------------------------------
module bba_word_unit import bba_pkg::*; (
  input  word_req_t req,
  input  word_t     data,
  output word_res_t res
);

  word_t avail;
  word_t run;
  word_t lowest;

  always_comb begin
    logic [CNT_W-1:0] gidx;
    avail = '0;
    run   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      gidx     = CNT_W'({req.word, BIT_W'(j)});
      avail[j] = data[j] && (gidx < TOTAL_CNT);
      run[j]   = (gidx >= req.start) && (gidx < req.stop);
    end
  end

  // isolate lowest set bit
  assign lowest = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    res.bit_pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        res.bit_pos = res.bit_pos | BIT_W'(j);
      end
    end
    res.found = |avail;
    if (req.alloc_one) begin
      res.new_data = data & ~lowest;
    end else if (req.fill) begin
      res.new_data = data | run;
    end else begin
      res.new_data = data & ~run;
    end
  end

endmodule

FILE: rtl/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq
// request sequencer: walks the bitmap one word per read-modify-write,
// keeps the free count and holds the result register
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_top_macros.svh"

module bba_seq import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_position,
  input  logic [CNT_W-1:0] in_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_block_index,
  output logic [1:0]       out_status,
  output logic [CNT_W-1:0] out_free_blocks,
  output mem_cmd_t         mem_cmd,
  output word_req_t        wreq,
  input  word_res_t        wres
);

  state_t                state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [CNT_W-1:0]      start_r, start_nxt;
  logic [CNT_W-1:0]      stop_r, stop_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic [WORD_IDX_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]      tot_after_r, tot_after_nxt;
  status_t               status_r, status_nxt;
  logic [IDX_W-1:0]      index_r, index_nxt;
  logic [CNT_W-1:0]      free_total_r, free_total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_index_r, out_index_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]      out_free_r, out_free_nxt;

  mode_t            req_mode;
  logic             req_fill;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] dn_n;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_m1;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] up_val;
  logic [CNT_W-1:0] dn_val;

  // request decode and saturating count update
  always_comb begin
    req_mode = mode_t'(in_mode);
    req_fill = (req_mode == MODE_FREE_ONE) || (req_mode == MODE_FREE_RANGE);
    cnt_eff  = (req_mode == MODE_FREE_ONE) ? CNT_W'(1) : in_count;
    dn_n     = (req_mode == MODE_ALLOC_ONE) ? CNT_W'(1) : cnt_eff;
    sum      = SUM_W'(in_position) + SUM_W'(cnt_eff);
    sum_m1   = sum - SUM_W'(1);
    room     = TOTAL_CNT - free_total_r;
    up_val   = (cnt_eff >= room) ? TOTAL_CNT : free_total_r + cnt_eff;
    dn_val   = (dn_n >= free_total_r) ? '0 : free_total_r - dn_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_total_r <= TOTAL_CNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    start_r      <= start_nxt;
    stop_r       <= stop_nxt;
    word_r       <= word_nxt;
    last_r       <= last_nxt;
    tot_after_r  <= tot_after_nxt;
    status_r     <= status_nxt;
    index_r      <= index_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    start_nxt      = start_r;
    stop_nxt       = stop_r;
    word_nxt       = word_r;
    last_nxt       = last_r;
    tot_after_nxt  = tot_after_r;
    status_nxt     = status_r;
    index_nxt      = index_r;
    free_total_nxt = free_total_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    in_ready       = 1'b0;
    mem_cmd        = '0;
    mem_cmd.rd_addr = word_r;
    mem_cmd.wr_addr = word_r;
    mem_cmd.wr_data = wres.new_data;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt      = req_mode;
          start_nxt     = CNT_W'(in_position);
          stop_nxt      = sum[CNT_W-1:0];
          index_nxt     = '0;
          status_nxt    = ST_DONE;
          tot_after_nxt = req_fill ? up_val : dn_val;
          if (req_mode == MODE_ALLOC_ONE) begin
            word_nxt  = '0;
            state_nxt = S_READ;
          end else if (sum > SUM_W'(TOTAL_BLOCKS)) begin
            status_nxt = ST_PAST_END;
            state_nxt  = S_DONE;
          end else if (cnt_eff == '0) begin
            state_nxt = S_DONE;
          end else begin
            word_nxt  = in_position[IDX_W-1:BIT_W];
            last_nxt  = sum_m1[IDX_W-1:BIT_W];
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        mem_cmd.rd_en = 1'b1;
        state_nxt     = S_CHECK;
      end
      S_CHECK: begin
        if (mode_r == MODE_ALLOC_ONE) begin
          if (wres.found) begin
            mem_cmd.wr_en = 1'b1;
            index_nxt     = {word_r, wres.bit_pos};
            state_nxt     = S_DONE;
          end else if (word_r == WORD_LAST) begin
            status_nxt = ST_NO_FREE;
            state_nxt  = S_DONE;
          end else begin
            word_nxt  = word_r + WORD_IDX_W'(1);
            state_nxt = S_READ;
          end
        end else begin
          mem_cmd.wr_en = 1'b1;
          if (word_r == last_r) begin
            state_nxt = S_DONE;
          end else begin
            word_nxt  = word_r + WORD_IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = index_r;
          out_status_nxt = status_r;
          if (status_r == ST_DONE) begin
            free_total_nxt = tot_after_r;
            out_free_nxt   = tot_after_r;
          end else begin
            out_free_nxt = free_total_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    wreq.alloc_one = (mode_r == MODE_ALLOC_ONE);
    wreq.fill      = (mode_r == MODE_FREE_ONE) || (mode_r == MODE_FREE_RANGE);
    wreq.word      = word_r;
    wreq.start     = start_r;
    wreq.stop      = stop_r;
  end

  assign out_valid       = out_valid_r;
  assign out_block_index = out_index_r;
  assign out_status      = out_status_r;
  assign out_free_blocks = out_free_r;

  `BBA_ASSERT_IMPL(a_total_bound, 1'b1, free_total_r <= TOTAL_CNT)
  `BBA_ASSERT_NEXT(a_accept_busy, in_valid && state_r == S_IDLE, state_r != S_IDLE)
  `BBA_ASSERT_IMPL(a_no_free_index, out_valid_r && out_status_r == ST_NO_FREE,
                   out_index_r == '0)
  `BBA_ASSERT_IMPL(a_range_walk, state_r == S_CHECK && mode_r != MODE_ALLOC_ONE,
                   word_r <= last_r)

endmodule

FILE: rtl/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// free-block bitmap allocator with a saturating free count
// ----------------------------------------------------------------------------
// usage:
//   in_if carries one request per transaction (mode, position, count);
//   out_if returns exactly one result per request, in order.
//   the bitmap is 32 words of 32 bits; one read-modify-write of a word
//   reads the registered-read store, then writes through the shared word unit.
//   allocate one: scans from word 0 to the first free bit, all words when full.
//   free one / ranges: one read-modify-write per word touched; a rejected or
//   empty range goes straight to the result without touching the map.
//   in_if.ready is high only while no request is in progress; the result
//   register lets a new request enter while the last result is not taken.
//   reset makes every block free at once (per-word valid bits, no sweep)
//   and sets the free count to 1024.
//   when out_if stalls, a finished request waits in its last state until
//   the result register empties.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top import bba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  bba_in_if.sink     in_if,
  bba_out_if.source  out_if
);

  mem_cmd_t  mem_cmd;
  word_t     rd_data;
  word_req_t wreq;
  word_res_t wres;

  bba_map_mem u_map_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .rd_data (rd_data)
  );

  bba_word_unit u_word_unit (
    .req  (wreq),
    .data (rd_data),
    .res  (wres)
  );

  bba_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_if.valid),
    .in_ready        (in_if.ready),
    .in_mode         (in_if.mode),
    .in_position     (in_if.position),
    .in_count        (in_if.count),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_block_index (out_if.block_index),
    .out_status      (out_if.status),
    .out_free_blocks (out_if.free_blocks),
    .mem_cmd         (mem_cmd),
    .wreq            (wreq),
    .wres            (wres)
  );

endmodule

FILE: bench/tb_bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_top
// drives allocate/free requests into the bitmap allocator and checks every
// result against a bit-accurate free map and saturating free count kept here;
// runs under three sender/receiver idling mixes with a long receiver hold
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_top;
  import bba_pkg::*;

  typedef struct {
    mode_t            mode;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] count;
  } alloc_req_t;

  typedef struct {
    logic [IDX_W-1:0] block_index;
    status_t          status;
    logic [CNT_W-1:0] free_blocks;
  } alloc_res_t;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  bitmap_block_allocator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  alloc_req_t pending_q[$];
  alloc_res_t expected_q[$];
  alloc_req_t offered;

  logic [TOTAL_BLOCKS-1:0] free_bits = '1;
  int free_count = TOTAL_BLOCKS;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req_seq;
  int hold_ack_seq = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int error_count = 0;
  int n_requests = 0;
  int n_done = 0;
  int n_no_free = 0;
  int n_past_end = 0;

  always #5 clk = ~clk;

  // reference behavior: one request in, one result out
  function automatic alloc_res_t allocator_predict(alloc_req_t req);
    alloc_res_t res;
    int b;
    int last;
    res.block_index = '0;
    res.status = ST_DONE;
    case (req.mode)
      MODE_ALLOC_ONE: begin
        b = 0;
        while (b < TOTAL_BLOCKS && !free_bits[b]) b++;
        if (b < TOTAL_BLOCKS) begin
          free_bits[b] = 1'b0;
          free_count = (free_count > 0) ? free_count - 1 : 0;
          res.block_index = IDX_W'(b);
        end else begin
          res.status = ST_NO_FREE;
        end
      end
      MODE_FREE_ONE: begin
        if (int'(req.position) >= TOTAL_BLOCKS) begin
          res.status = ST_PAST_END;
        end else begin
          free_bits[req.position] = 1'b1;
          free_count = (free_count + 1 > TOTAL_BLOCKS) ? TOTAL_BLOCKS : free_count + 1;
        end
      end
      default: begin
        last = int'(req.position) + int'(req.count);
        if (last > TOTAL_BLOCKS) begin
          res.status = ST_PAST_END;
        end else if (req.count != 0) begin
          for (b = int'(req.position); b < last; b++)
            free_bits[b] = (req.mode == MODE_FREE_RANGE);
          if (req.mode == MODE_FREE_RANGE)
            free_count = (free_count + int'(req.count) > TOTAL_BLOCKS) ? TOTAL_BLOCKS
                         : free_count + int'(req.count);
          else
            free_count = (int'(req.count) >= free_count) ? 0 : free_count - int'(req.count);
        end
      end
    endcase
    res.free_blocks = CNT_W'(free_count);
    return res;
  endfunction

  task automatic queue_request(mode_t mode, int position, int count);
    alloc_req_t req;
    req.mode = mode;
    req.position = IDX_W'(position);
    req.count = CNT_W'(count);
    pending_q = {pending_q, req};
  endtask

  task automatic queue_range(mode_t mode);
    int pos;
    int room;
    int pick;
    pos = $urandom_range(TOTAL_BLOCKS - 1, 0);
    if ($urandom_range(3) == 0) pos = $urandom_range(63, 0);
    room = TOTAL_BLOCKS - pos;
    pick = $urandom_range(99, 0);
    if (pick < 4)
      queue_request(mode, pos, 0);
    else if (pick < 12)
      queue_request(mode, pos, $urandom_range(2047, room + 1));
    else if (pick < 20)
      queue_request(mode, pos, $urandom_range(room, 0));
    else
      queue_request(mode, pos, $urandom_range((room < 48) ? room : 48, 1));
  endtask

  task automatic queue_random(int n);
    int added;
    int pick;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99, 0);
      if (pick < 2) begin
        // exhaust the map, then recycle one block
        queue_request(MODE_ALLOC_RANGE, 0, TOTAL_BLOCKS);
        queue_request(MODE_ALLOC_ONE, 0, 0);
        queue_request(MODE_FREE_ONE, $urandom_range(TOTAL_BLOCKS - 1, 0), 0);
        queue_request(MODE_ALLOC_ONE, 0, 0);
        queue_request(MODE_ALLOC_ONE, 0, 0);
        queue_request(MODE_FREE_RANGE, 0, $urandom_range(TOTAL_BLOCKS, 1));
        added += 6;
      end else begin
        if (pick < 37)
          queue_request(MODE_ALLOC_ONE, $urandom_range(TOTAL_BLOCKS - 1, 0),
                        $urandom_range(2047, 0));
        else if (pick < 57)
          queue_request(MODE_FREE_ONE, $urandom_range(TOTAL_BLOCKS - 1, 0),
                        $urandom_range(2047, 0));
        else if (pick < 77)
          queue_range(MODE_ALLOC_RANGE);
        else
          queue_range(MODE_FREE_RANGE);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_ch.valid);
  endtask

  // request driver
  always @(posedge clk) begin
    alloc_res_t predicted;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_ALLOC_ONE;
      in_ch.position <= '0;
      in_ch.count <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = allocator_predict(offered);
        expected_q = {expected_q, predicted};
        n_requests++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          offered = pending_q.pop_front();
          in_ch.mode <= offered.mode;
          in_ch.position <= offered.position;
          in_ch.count <= offered.count;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    alloc_res_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_ch.block_index !== exp_res.block_index) begin
            $error("block_index: expected %0d, got %0d", exp_res.block_index,
                   out_ch.block_index);
            error_count++;
          end
          if (out_ch.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_ch.status);
            error_count++;
          end
          if (out_ch.free_blocks !== exp_res.free_blocks) begin
            $error("free_blocks: expected %0d, got %0d", exp_res.free_blocks,
                   out_ch.free_blocks);
            error_count++;
          end
          case (exp_res.status)
            ST_NO_FREE:  n_no_free++;
            ST_PAST_END: n_past_end++;
            default:     n_done++;
          endcase
        end
      end
      if (hold_ack_seq != hold_req_seq) begin
        hold_ack_seq = hold_req_seq;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction while work is outstanding
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (pending_q.size() != 0 || expected_q.size() != 0 || in_ch.valid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    send_idle_pct = 38;
    recv_stall_pct = 87;
    hold_req_seq = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    queue_request(MODE_ALLOC_ONE, 0, 0);
    queue_request(MODE_ALLOC_ONE, 1023, 2047);
    queue_request(MODE_FREE_ONE, 0, 0);
    queue_request(MODE_FREE_ONE, 0, 0);
    queue_request(MODE_FREE_ONE, 1023, 2047);
    queue_request(MODE_ALLOC_RANGE, 0, 1024);
    queue_request(MODE_ALLOC_ONE, 0, 0);
    queue_request(MODE_ALLOC_RANGE, 5, 3);
    queue_request(MODE_FREE_RANGE, 1000, 24);
    queue_request(MODE_FREE_RANGE, 1000, 25);
    queue_request(MODE_FREE_RANGE, 1023, 2047);
    queue_request(MODE_ALLOC_RANGE, 0, 0);
    queue_request(MODE_FREE_RANGE, 1023, 0);
    queue_request(MODE_ALLOC_ONE, 0, 0);
    queue_request(MODE_FREE_RANGE, 0, 1024);
    queue_request(MODE_ALLOC_RANGE, 512, 1);
    queue_request(MODE_FREE_RANGE, 0, 1025);
    queue_request(MODE_FREE_ONE, 341, 1365);
    queue_request(MODE_FREE_ONE, 682, 682);
    queue_request(MODE_ALLOC_RANGE, 1023, 1);
    queue_request(MODE_ALLOC_ONE, 0, 0);
    queue_request(MODE_FREE_RANGE, 0, 1024);
    queue_random(410);
    wait_drained();

    send_idle_pct = 87;
    recv_stall_pct = 38;
    queue_random(430);
    wait_drained();

    // no idling, with one long receiver hold while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(440);
    hold_req_seq++;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb summary: %0d requests under three idling mixes and a long output hold",
             n_requests);
    $display("tb summary: %0d done, %0d no free block, %0d range past end",
             n_done, n_no_free, n_past_end);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_if.sv
rtl/bba_map_mem.sv
rtl/bba_word_unit.sv
rtl/bba_seq.sv
rtl/bitmap_block_allocator_top.sv
bench/tb_bitmap_block_allocator_top.sv
